// ===== rtl/vpnv4_route_attribute_parser_core_assert.svh =====
`ifndef VPNV4_ROUTE_ATTRIBUTE_PARSER_CORE_ASSERT_SVH
`define VPNV4_ROUTE_ATTRIBUTE_PARSER_CORE_ASSERT_SVH
// Property that must hold at every clock edge outside reset.
`define RP_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define RP_CHK_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`endif

// ===== rtl/rp_pkg.sv =====
package rp_pkg;
  localparam int RP_MAX_ROUTES = 256;
  localparam int RP_QDEPTH = 4;

  localparam logic [2:0] KIND_REACH = 3'd0;
  localparam logic [2:0] KIND_WDRAW = 3'd1;
  localparam logic [2:0] KIND_NHOP = 3'd2;
  localparam logic [2:0] KIND_END_OK = 3'd3;
  localparam logic [2:0] KIND_END_ERR = 3'd4;

  localparam logic [7:0] CODE_REACH = 8'd14;
  localparam logic [7:0] CODE_UNREACH = 8'd15;
  localparam logic [23:0] VPNV4_FAMILY = 24'h000180;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  idx;
    logic [19:0] label;
    logic [15:0] asn;
    logic [31:0] num;
    logic [5:0]  plen;
    logic [31:0] addr;
  } rp_res_t;

  // Everything one input byte produces: an optional route or next hop and
  // an optional end status.
  typedef struct packed {
    logic    has_main;
    rp_res_t main;
    logic    has_end;
    logic    end_err;
  } rp_ent_t;
endpackage

// ===== rtl/rp_front.sv =====
module rp_front import rp_pkg::*; #(
  parameter int MAX_ROUTES = RP_MAX_ROUTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       end_of_blob,
  output rp_ent_t    ent,
  output logic       push
);
  localparam int CW = $clog2(MAX_ROUTES + 1);

  localparam logic [3:0] PH_FLAGS = 4'd0;
  localparam logic [3:0] PH_CODE = 4'd1;
  localparam logic [3:0] PH_LEN_HI = 4'd2;
  localparam logic [3:0] PH_LEN_LO = 4'd3;
  localparam logic [3:0] PH_SKIP = 4'd4;
  localparam logic [3:0] PH_HDR = 4'd5;
  localparam logic [3:0] PH_NHLEN = 4'd6;
  localparam logic [3:0] PH_NH = 4'd7;
  localparam logic [3:0] PH_SNPA = 4'd8;
  localparam logic [3:0] PH_RLEN = 4'd9;
  localparam logic [3:0] PH_RBODY = 4'd10;
  localparam logic [3:0] PH_DRAIN = 4'd11;

  logic [3:0]    phase_r, phase_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [7:0]    fbc_r, fbc_nxt;
  logic [7:0]    rbl_r, rbl_nxt;
  logic [23:0]   lab_r, lab_nxt;
  logic [47:0]   rd_r, rd_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [CW-1:0] rcnt_r, rcnt_nxt;
  logic [CW-1:0] wcnt_r, wcnt_nxt;
  logic          err_r, err_nxt;

  logic          is_reach, is_unreach, failed;
  logic [CW-1:0] cnt_sel;
  logic [15:0]   rem_v;
  logic [8:0]    nbytes;
  logic [7:0]    off;

  assign is_reach = (code_r == CODE_REACH);
  assign is_unreach = (code_r == CODE_UNREACH);
  assign cnt_sel = is_reach ? rcnt_r : wcnt_r;
  assign rem_v = {rem_r[15:8], data_byte};
  assign nbytes = ({1'b0, data_byte} + 9'd7) >> 3;
  assign off = fbc_r - 8'd11;

  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    code_nxt = code_r;
    rem_nxt = rem_r;
    fbc_nxt = fbc_r;
    rbl_nxt = rbl_r;
    lab_nxt = lab_r;
    rd_nxt = rd_r;
    addr_nxt = addr_r;
    rcnt_nxt = rcnt_r;
    wcnt_nxt = wcnt_r;
    err_nxt = err_r;
    failed = 1'b0;
    ent = '0;
    unique case (phase_r)
      PH_FLAGS: begin
        flags_nxt = data_byte;
        phase_nxt = PH_CODE;
      end
      PH_CODE: begin
        code_nxt = data_byte;
        rem_nxt = '0;
        phase_nxt = flags_r[4] ? PH_LEN_HI : PH_LEN_LO;
      end
      PH_LEN_HI: begin
        rem_nxt = {data_byte, 8'h00};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        rem_nxt = rem_v;
        if ((is_reach && rem_v < 16'd4) || (is_unreach && rem_v < 16'd3)) begin
          failed = 1'b1;
        end else if (rem_v == 16'd0) begin
          phase_nxt = PH_FLAGS;
        end else if (is_reach || is_unreach) begin
          phase_nxt = PH_HDR;
          fbc_nxt = '0;
          lab_nxt = '0;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_DRAIN: begin
      end
      default: begin
        if (rem_r == 16'd0) begin
          failed = 1'b1;
        end else begin
          unique case (phase_r)
            PH_HDR: begin
              lab_nxt = {lab_r[15:0], data_byte};
              fbc_nxt = fbc_r + 8'd1;
              if (fbc_nxt >= 8'd3) begin
                if (lab_nxt != VPNV4_FAMILY) phase_nxt = PH_SKIP;
                else phase_nxt = is_reach ? PH_NHLEN : PH_RLEN;
              end
            end
            PH_NHLEN: begin
              if ({8'h00, data_byte} > rem_r - 16'd1) begin
                failed = 1'b1;
              end else begin
                rbl_nxt = data_byte;
                fbc_nxt = data_byte;
                addr_nxt = '0;
                phase_nxt = (data_byte != 8'd0) ? PH_NH : PH_SNPA;
              end
            end
            PH_NH: begin
              addr_nxt = {addr_r[23:0], data_byte};
              fbc_nxt = fbc_r - 8'd1;
              if (fbc_nxt == 8'd0) begin
                if (rbl_r == 8'd4) begin
                  ent.has_main = 1'b1;
                  ent.main.kind = KIND_NHOP;
                  ent.main.addr = addr_nxt;
                end
                phase_nxt = PH_SNPA;
              end
            end
            PH_SNPA: phase_nxt = PH_RLEN;
            PH_RLEN: begin
              if (cnt_sel >= CW'(MAX_ROUTES)) begin
                phase_nxt = PH_SKIP;
              end else if (data_byte < 8'd88 || data_byte > 8'd120 ||
                           ({7'd0, nbytes} + 16'd1) > rem_r) begin
                failed = 1'b1;
              end else begin
                rbl_nxt = data_byte;
                fbc_nxt = '0;
                lab_nxt = '0;
                rd_nxt = '0;
                addr_nxt = '0;
                phase_nxt = PH_RBODY;
              end
            end
            PH_RBODY: begin
              if (fbc_r < 8'd3) begin
                lab_nxt = {lab_r[15:0], data_byte};
              end else if (fbc_r < 8'd11) begin
                rd_nxt = {rd_r[39:0], data_byte};
                // Bytes three and four hold the distinguisher type.
                if (fbc_r == 8'd4 && rd_nxt[15:0] != 16'd0) failed = 1'b1;
              end else if (off < 8'd4) begin
                unique case (off[1:0])
                  2'd0: addr_nxt = addr_r | {data_byte, 24'd0};
                  2'd1: addr_nxt = addr_r | {8'd0, data_byte, 16'd0};
                  2'd2: addr_nxt = addr_r | {16'd0, data_byte, 8'd0};
                  default: addr_nxt = addr_r | {24'd0, data_byte};
                endcase
              end
              if (!failed) begin
                fbc_nxt = fbc_r + 8'd1;
                if ({1'b0, fbc_nxt} >= (({1'b0, rbl_r} + 9'd7) >> 3)) begin
                  ent.has_main = 1'b1;
                  ent.main.kind = is_reach ? KIND_REACH : KIND_WDRAW;
                  ent.main.idx = 8'(cnt_sel);
                  ent.main.label = lab_nxt[23:4];
                  ent.main.asn = rd_nxt[47:32];
                  ent.main.num = rd_nxt[31:0];
                  ent.main.plen = 6'(rbl_r - 8'd88);
                  ent.main.addr = addr_nxt;
                  if (is_reach) rcnt_nxt = rcnt_r + CW'(1);
                  else wcnt_nxt = wcnt_r + CW'(1);
                  phase_nxt = PH_RLEN;
                end
              end
            end
            default: begin
            end
          endcase
          if (!failed) begin
            rem_nxt = rem_r - 16'd1;
            if (rem_nxt == 16'd0) begin
              if (phase_nxt == PH_SKIP || phase_nxt == PH_RLEN) phase_nxt = PH_FLAGS;
              else failed = 1'b1;
            end
          end
        end
      end
    endcase
    // A next hop that used up the attribute is still reported before the error.
    if (failed) begin
      err_nxt = 1'b1;
      phase_nxt = PH_DRAIN;
    end
    if (end_of_blob) begin
      ent.has_end = 1'b1;
      ent.end_err = err_nxt || (phase_nxt != PH_FLAGS);
      phase_nxt = PH_FLAGS;
      flags_nxt = '0;
      code_nxt = '0;
      rem_nxt = '0;
      fbc_nxt = '0;
      rbl_nxt = '0;
      lab_nxt = '0;
      rd_nxt = '0;
      addr_nxt = '0;
      rcnt_nxt = '0;
      wcnt_nxt = '0;
      err_nxt = 1'b0;
    end
  end

  assign push = take && (ent.has_main || ent.has_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAGS;
      flags_r <= '0;
      code_r <= '0;
      rem_r <= '0;
      fbc_r <= '0;
      rbl_r <= '0;
      lab_r <= '0;
      rd_r <= '0;
      addr_r <= '0;
      rcnt_r <= '0;
      wcnt_r <= '0;
      err_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      code_r <= code_nxt;
      rem_r <= rem_nxt;
      fbc_r <= fbc_nxt;
      rbl_r <= rbl_nxt;
      lab_r <= lab_nxt;
      rd_r <= rd_nxt;
      addr_r <= addr_nxt;
      rcnt_r <= rcnt_nxt;
      wcnt_r <= wcnt_nxt;
      err_r <= err_nxt;
    end
  end
endmodule

// ===== rtl/rp_queue.sv =====
module rp_queue import rp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  rp_ent_t wdata,
  input  logic    pop,
  output rp_ent_t head,
  output logic    full,
  output logic    empty
);
  `include "vpnv4_route_attribute_parser_core_assert.svh"

  localparam int AW = $clog2(RP_QDEPTH);

  rp_ent_t      mem [RP_QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full = (cnt_r == (AW + 1)'(RP_QDEPTH));
  assign empty = (cnt_r == '0);
  assign head = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop) rp_r <= rp_r + AW'(1);
      if (push && !pop) cnt_r <= cnt_r + (AW + 1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (AW + 1)'(1);
    end
  end

  `RP_CHK(a_no_overflow, !(push && full), "item pushed into full queue")
  `RP_CHK(a_no_underflow, !(pop && empty), "item popped from empty queue")
  `RP_CHK_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + (AW + 1)'(1),
               "queue count did not advance on push")
endmodule

// ===== rtl/rp_back.sv =====
module rp_back import rp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rp_ent_t     head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_entry_index,
  output logic [19:0] out_mpls_label,
  output logic [15:0] out_rd_asn,
  output logic [31:0] out_rd_number,
  output logic [5:0]  out_prefix_len,
  output logic [31:0] out_address,
  output logic        out_last_result
);
  // Set once the route part of a two-result entry has gone out.
  logic    sub_r;
  logic    show_main;
  rp_res_t r;

  assign show_main = head.has_main && !sub_r;
  assign out_valid = !empty;

  always_comb begin
    r = '0;
    if (show_main) r = head.main;
    else r.kind = head.end_err ? KIND_END_ERR : KIND_END_OK;
  end

  assign out_result_kind = r.kind;
  assign out_entry_index = r.idx;
  assign out_mpls_label = r.label;
  assign out_rd_asn = r.asn;
  assign out_rd_number = r.num;
  assign out_prefix_len = r.plen;
  assign out_address = r.addr;
  assign out_last_result = !(show_main && head.has_end);

  assign pop = out_valid && out_ready && out_last_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      sub_r <= !out_last_result;
    end
  end
endmodule

// ===== rtl/vpnv4_route_attribute_parser_core.sv =====
// A result is registered in the queue and offered from there, behind any results still queued.
// Throughput: one byte per cycle while the queue is not full; the front parse state machine updates once per byte.
// A byte causing a route and an end status gives two results from the back end, the route first.
// A four-entry queue between parser and output lets either side stall alone.
// Reset (rst_n low, synchronous) empties the queue and returns to the flags byte.
module vpnv4_route_attribute_parser_core import rp_pkg::*; #(
  parameter int MAX_ROUTES = RP_MAX_ROUTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_blob,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_entry_index,
  output logic [19:0] out_mpls_label,
  output logic [15:0] out_rd_asn,
  output logic [31:0] out_rd_number,
  output logic [5:0]  out_prefix_len,
  output logic [31:0] out_address,
  output logic        out_last_result
);
  rp_ent_t ent, head;
  logic    push, pop, full, empty, take;

  assign in_ready = !full;
  assign take = in_valid && in_ready;

  rp_front #(.MAX_ROUTES(MAX_ROUTES)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .data_byte(in_data_byte),
    .end_of_blob(in_end_of_blob), .ent(ent), .push(push)
  );

  rp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(ent), .pop(pop),
    .head(head), .full(full), .empty(empty)
  );

  rp_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .empty(empty), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_entry_index(out_entry_index),
    .out_mpls_label(out_mpls_label), .out_rd_asn(out_rd_asn),
    .out_rd_number(out_rd_number), .out_prefix_len(out_prefix_len),
    .out_address(out_address), .out_last_result(out_last_result)
  );
endmodule
